FILE: hdl/dct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dct_pkg;

  localparam int unsigned EnergyW  = 20;
  localparam int unsigned SumW     = 21;
  localparam int unsigned TimeW    = 40;
  localparam int unsigned ChainW   = 32;
  localparam int unsigned HitsW    = 8;
  localparam int unsigned ChanW    = 10;
  localparam int unsigned InDataW  = 152;
  localparam int unsigned OutDataW = 208;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    REG_CUT_MODE       = 3'd0,
    REG_PROMPT_E_LOW   = 3'd1,
    REG_PROMPT_E_HIGH  = 3'd2,
    REG_DELAYED_E_LOW  = 3'd3,
    REG_DELAYED_E_HIGH = 3'd4,
    REG_GAP_LOW        = 3'd5,
    REG_GAP_HIGH       = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_index_t;

  localparam logic [EnergyW-1:0] PromptLowReset   = 20'd101568;
  localparam logic [EnergyW-1:0] PromptHighReset  = 20'd102848;
  localparam logic [EnergyW-1:0] DelayedLowReset  = 20'd30720;
  localparam logic [EnergyW-1:0] DelayedHighReset = 20'd32000;
  localparam logic [TimeW-1:0]   GapLowReset      = 40'd10;
  localparam logic [TimeW-1:0]   GapHighReset     = 40'd1800000;
  localparam logic [ChainW-1:0]  ChainReset       = 32'd1;
  localparam logic [HitsW-1:0]   PairHits         = 8'd2;

  typedef struct packed {
    logic               pass;
    logic [EnergyW-1:0] energy;
  } energy_pick_t;

  function automatic logic in_window(input logic [EnergyW-1:0] v,
                                     input logic [EnergyW-1:0] lo,
                                     input logic [EnergyW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  // broad mode tests the total; narrow mode prefers the second multiplet
  function automatic energy_pick_t pick_energy(input logic               broad,
                                               input logic [EnergyW-1:0] tot,
                                               input logic [EnergyW-1:0] e0,
                                               input logic [EnergyW-1:0] e1,
                                               input logic [EnergyW-1:0] lo,
                                               input logic [EnergyW-1:0] hi);
    energy_pick_t r;
    r.pass   = 1'b0;
    r.energy = tot;
    if (broad) begin
      r.pass = in_window(tot, lo, hi);
    end else if (in_window(e1, lo, hi)) begin
      r.pass   = 1'b1;
      r.energy = e1;
    end else if (in_window(e0, lo, hi)) begin
      r.pass   = 1'b1;
      r.energy = e0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/delayed_coincidence_tagger.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                      | Contents
// s_       | in  | s_tvalid / s_tready            | one detector event per transaction
// m_       | out | m_tvalid / m_tready            | one coincidence tag per transaction
// apb      | in  | psel, penable, pwrite, pready  | window and mode registers, 8-byte stride
//
// One event per cycle while s_tready is high; a tag is registered on m_, or into
// the skid entry while m_ is stalled. Each event is judged combinationally:
// window compares and one 40-bit subtract against the held prompt.
// An output register plus one skid entry keep s_tready high while a tag waits;
// s_tready drops only when both hold a tag.
// rst (synchronous) restores register defaults, chain 1 and no armed prompt.

module delayed_coincidence_tagger (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // chain_id, hit_count, channel_id, event_time, total_energy,
  // first_hit_energy, second_hit_energy (lowest first), 2 pad bits
  input  wire logic [dct_pkg::InDataW-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // tag_prompt_channel, tag_delayed_channel, tag_prompt_energy,
  // tag_delayed_energy, tag_prompt_time, tag_delayed_time, energy_sum,
  // time_gap (lowest first), 7 pad bits
  output logic [dct_pkg::OutDataW-1:0]       m_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dct_pkg::AddrW-1:0]     paddr,
  input  wire logic [dct_pkg::CfgDataW-1:0]  pwdata,
  output logic [dct_pkg::CfgDataW-1:0]       prdata,
  output logic                               pready
);

  logic                          cut_mode;
  logic [dct_pkg::EnergyW-1:0]   prompt_energy_low;
  logic [dct_pkg::EnergyW-1:0]   prompt_energy_high;
  logic [dct_pkg::EnergyW-1:0]   delayed_energy_low;
  logic [dct_pkg::EnergyW-1:0]   delayed_energy_high;
  logic [dct_pkg::TimeW-1:0]     gap_low;
  logic [dct_pkg::TimeW-1:0]     gap_high;

  logic [dct_pkg::ChainW-1:0]    current_chain;
  logic                          prompt_armed;
  logic [dct_pkg::EnergyW-1:0]   held_prompt_energy;
  logic [dct_pkg::TimeW-1:0]     held_prompt_time;
  logic [dct_pkg::ChanW-1:0]     held_prompt_channel;

  logic [dct_pkg::OutDataW-1:0]  skid_data;
  logic                          skid_valid;

  dct_pkg::reg_index_t           reg_sel;
  logic                          cfg_write;

  logic [dct_pkg::ChainW-1:0]    in_chain;
  logic [dct_pkg::HitsW-1:0]     in_hits;
  logic [dct_pkg::ChanW-1:0]     in_chan;
  logic [dct_pkg::TimeW-1:0]     in_time;
  logic [dct_pkg::EnergyW-1:0]   in_tot;
  logic [dct_pkg::EnergyW-1:0]   in_e0;
  logic [dct_pkg::EnergyW-1:0]   in_e1;

  logic                          accept;
  logic                          same_chain;
  logic                          pair_event;
  dct_pkg::energy_pick_t         prompt_pick;
  dct_pkg::energy_pick_t         delayed_pick;
  logic [dct_pkg::TimeW-1:0]     gap;
  logic                          gap_ok;
  logic                          arm_now;
  logic                          tag_valid;
  logic [dct_pkg::OutDataW-1:0]  tag_data;
  logic                          out_load;

  // configuration
  assign pready    = 1'b1;
  assign reg_sel   = dct_pkg::reg_index_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_sel)
      dct_pkg::REG_CUT_MODE:       prdata = {63'd0, cut_mode};
      dct_pkg::REG_PROMPT_E_LOW:   prdata = {44'd0, prompt_energy_low};
      dct_pkg::REG_PROMPT_E_HIGH:  prdata = {44'd0, prompt_energy_high};
      dct_pkg::REG_DELAYED_E_LOW:  prdata = {44'd0, delayed_energy_low};
      dct_pkg::REG_DELAYED_E_HIGH: prdata = {44'd0, delayed_energy_high};
      dct_pkg::REG_GAP_LOW:        prdata = {24'd0, gap_low};
      dct_pkg::REG_GAP_HIGH:       prdata = {24'd0, gap_high};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_mode            <= 1'b0;
      prompt_energy_low   <= dct_pkg::PromptLowReset;
      prompt_energy_high  <= dct_pkg::PromptHighReset;
      delayed_energy_low  <= dct_pkg::DelayedLowReset;
      delayed_energy_high <= dct_pkg::DelayedHighReset;
      gap_low             <= dct_pkg::GapLowReset;
      gap_high            <= dct_pkg::GapHighReset;
    end else if (cfg_write) begin
      case (reg_sel)
        dct_pkg::REG_CUT_MODE:       cut_mode            <= pwdata[0];
        dct_pkg::REG_PROMPT_E_LOW:   prompt_energy_low   <= pwdata[19:0];
        dct_pkg::REG_PROMPT_E_HIGH:  prompt_energy_high  <= pwdata[19:0];
        dct_pkg::REG_DELAYED_E_LOW:  delayed_energy_low  <= pwdata[19:0];
        dct_pkg::REG_DELAYED_E_HIGH: delayed_energy_high <= pwdata[19:0];
        dct_pkg::REG_GAP_LOW:        gap_low             <= pwdata[39:0];
        dct_pkg::REG_GAP_HIGH:       gap_high            <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  // event evaluation
  assign in_chain = s_tdata[31:0];
  assign in_hits  = s_tdata[39:32];
  assign in_chan  = s_tdata[49:40];
  assign in_time  = s_tdata[89:50];
  assign in_tot   = s_tdata[109:90];
  assign in_e0    = s_tdata[129:110];
  assign in_e1    = s_tdata[149:130];

  assign s_tready   = !skid_valid;
  assign accept     = s_tvalid && s_tready;
  assign same_chain = (in_chain == current_chain);
  assign pair_event = same_chain && (in_hits == dct_pkg::PairHits);

  assign prompt_pick  = dct_pkg::pick_energy(cut_mode, in_tot, in_e0, in_e1,
                                             prompt_energy_low, prompt_energy_high);
  assign delayed_pick = dct_pkg::pick_energy(cut_mode, in_tot, in_e0, in_e1,
                                             delayed_energy_low, delayed_energy_high);

  assign gap    = in_time - held_prompt_time;
  assign gap_ok = (in_time > held_prompt_time) && (gap > gap_low) && (gap < gap_high);

  assign arm_now   = accept && pair_event && !prompt_armed && prompt_pick.pass;
  assign tag_valid = accept && pair_event && prompt_armed && gap_ok && delayed_pick.pass;

  assign tag_data = {7'd0,
                     gap,
                     {1'b0, held_prompt_energy} + {1'b0, delayed_pick.energy},
                     in_time,
                     held_prompt_time,
                     delayed_pick.energy,
                     held_prompt_energy,
                     in_chan,
                     held_prompt_channel};

  always_ff @(posedge clk) begin
    if (rst) begin
      current_chain <= dct_pkg::ChainReset;
      prompt_armed  <= 1'b0;
    end else if (accept) begin
      if (!same_chain) begin
        current_chain <= in_chain;
        prompt_armed  <= 1'b0;
      end else if (arm_now) begin
        prompt_armed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arm_now) begin
      held_prompt_energy  <= prompt_pick.energy;
      held_prompt_time    <= in_time;
      held_prompt_channel <= in_chan;
    end
  end

  // output register and skid entry
  assign out_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      m_tvalid   <= skid_valid || tag_valid;
      skid_valid <= 1'b0;
    end else if (tag_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= skid_valid ? skid_data : tag_data;
    end
    if (!out_load && tag_valid) begin
      skid_data <= tag_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry holds a tag while output register is empty");

  a_tag_needs_prompt: assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> prompt_armed && same_chain)
    else $error("tag emitted without an armed prompt in the current chain");

  a_new_chain_disarms: assert property (@(posedge clk) disable iff (rst)
    (accept && !same_chain) |=> !prompt_armed && !m_tvalid || !prompt_armed)
    else $error("prompt still armed after chain change");

  a_arm_from_event: assert property (@(posedge clk) disable iff (rst)
    $rose(prompt_armed) |-> $past(arm_now))
    else $error("prompt armed without a qualifying event");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 400000;
  localparam logic [63:0] EnergyMask = 64'hF_FFFF;
  localparam logic [63:0] TimeMask   = 64'hFF_FFFF_FFFF;

  // field order matches tdata, lowest bits last in the list
  typedef struct packed {
    logic [1:0]                  pad;
    logic [dct_pkg::EnergyW-1:0] e1;
    logic [dct_pkg::EnergyW-1:0] e0;
    logic [dct_pkg::EnergyW-1:0] tot;
    logic [dct_pkg::TimeW-1:0]   t;
    logic [dct_pkg::ChanW-1:0]   chan;
    logic [dct_pkg::HitsW-1:0]   hits;
    logic [dct_pkg::ChainW-1:0]  chain;
  } event_t;

  typedef struct packed {
    logic [6:0]                  pad;
    logic [dct_pkg::TimeW-1:0]   gap;
    logic [dct_pkg::SumW-1:0]    sum;
    logic [dct_pkg::TimeW-1:0]   d_t;
    logic [dct_pkg::TimeW-1:0]   p_t;
    logic [dct_pkg::EnergyW-1:0] d_en;
    logic [dct_pkg::EnergyW-1:0] p_en;
    logic [dct_pkg::ChanW-1:0]   d_chan;
    logic [dct_pkg::ChanW-1:0]   p_chan;
  } tag_t;

  typedef enum logic [1:0] {
    BY_PREDICTOR = 2'd0,
    TYPED_NONE   = 2'd1,
    TYPED_TAG    = 2'd2
  } check_kind_t;

  typedef struct packed {
    check_kind_t kind;
    tag_t        tag;
    event_t      ev;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  wire                          s_tready;
  logic [dct_pkg::InDataW-1:0]  s_tdata = '0;
  wire                          m_tvalid;
  logic                         m_tready = 1'b0;
  wire [dct_pkg::OutDataW-1:0]  m_tdata;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [dct_pkg::AddrW-1:0]    paddr = '0;
  logic [dct_pkg::CfgDataW-1:0] pwdata = '0;
  wire [dct_pkg::CfgDataW-1:0]  prdata;
  wire                          pready;

  delayed_coincidence_tagger uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadow
  logic                        cfg_broad;
  logic [dct_pkg::EnergyW-1:0] cfg_p_lo, cfg_p_hi, cfg_d_lo, cfg_d_hi;
  logic [dct_pkg::TimeW-1:0]   cfg_g_lo, cfg_g_hi;

  // coincidence state
  logic [dct_pkg::ChainW-1:0]  cur_chain;
  bit                          armed;
  logic [dct_pkg::EnergyW-1:0] held_en;
  logic [dct_pkg::TimeW-1:0]   held_t;
  logic [dct_pkg::ChanW-1:0]   held_chan;

  tag_t pending_tags[$];
  row_t directed_rows[$];

  int mismatches = 0;
  int events_sent = 0;
  int tags_checked = 0;
  int settings_used = 1;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  function automatic bit window_pick(input event_t ev,
                                     input logic [dct_pkg::EnergyW-1:0] lo,
                                     input logic [dct_pkg::EnergyW-1:0] hi,
                                     output logic [dct_pkg::EnergyW-1:0] en);
    en = ev.tot;
    if (cfg_broad) return (ev.tot > lo) && (ev.tot < hi);
    if (ev.e1 > lo && ev.e1 < hi) begin
      en = ev.e1;
      return 1'b1;
    end
    if (ev.e0 > lo && ev.e0 < hi) begin
      en = ev.e0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_tag(input event_t ev, output tag_t tag);
    logic [dct_pkg::EnergyW-1:0] en;
    logic [dct_pkg::TimeW-1:0]   gap;
    tag = '0;
    if (ev.chain != cur_chain) begin
      cur_chain = ev.chain;
      armed = 1'b0;
      return 1'b0;
    end
    if (ev.hits != dct_pkg::PairHits) return 1'b0;
    if (!armed) begin
      if (window_pick(ev, cfg_p_lo, cfg_p_hi, en)) begin
        held_en = en;
        held_t = ev.t;
        held_chan = ev.chan;
        armed = 1'b1;
      end
      return 1'b0;
    end
    if (ev.t <= held_t) return 1'b0;
    gap = ev.t - held_t;
    if (!(gap > cfg_g_lo && gap < cfg_g_hi)) return 1'b0;
    if (!window_pick(ev, cfg_d_lo, cfg_d_hi, en)) return 1'b0;
    tag.p_chan = held_chan;
    tag.d_chan = ev.chan;
    tag.p_en   = held_en;
    tag.d_en   = en;
    tag.p_t    = held_t;
    tag.d_t    = ev.t;
    tag.sum    = {1'b0, held_en} + {1'b0, en};
    tag.gap    = gap;
    return 1'b1;
  endfunction

  function automatic event_t mk_event(input logic [31:0] chain, input logic [7:0] hits,
                                      input logic [9:0] chan, input logic [39:0] t,
                                      input logic [19:0] tot, input logic [19:0] e0,
                                      input logic [19:0] e1);
    event_t ev;
    ev = '0;
    ev.chain = chain;
    ev.hits  = hits;
    ev.chan  = chan;
    ev.t     = t;
    ev.tot   = tot;
    ev.e0    = e0;
    ev.e1    = e1;
    return ev;
  endfunction

  function automatic void add_row(input event_t ev, input check_kind_t kind, input tag_t tag);
    row_t r;
    r.ev = ev;
    r.kind = kind;
    r.tag = tag;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  // mostly strictly inside the window, sometimes on a bound, sometimes anywhere
  function automatic logic [63:0] pick_value(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [63:0] mask);
    logic [63:0] r;
    int roll;
    roll = $urandom_range(99, 0);
    r = {$urandom, $urandom} & mask;
    if (roll < 65 && hi > lo + 1) r = lo + 1 + r % (hi - lo - 1);
    else if (roll < 75) r = lo;
    else if (roll < 85) r = hi;
    return r & mask;
  endfunction

  function automatic logic [63:0] span_above(input logic [63:0] lo,
                                             input int unsigned max_span,
                                             input logic [63:0] mask);
    logic [63:0] hi;
    hi = lo + 64'($urandom_range(max_span, 2));
    return (hi > mask) ? mask : hi;
  endfunction

  function automatic event_t rand_event();
    event_t      ev;
    int          roll;
    logic [63:0] lo, hi;
    ev = '0;
    roll = $urandom_range(99, 0);
    if (roll < 92) ev.chain = cur_chain;
    else if (roll < 96) ev.chain = cur_chain + 1;
    else ev.chain = $urandom;
    ev.hits = ($urandom_range(99, 0) < 85) ? dct_pkg::PairHits :
              dct_pkg::HitsW'($urandom_range(255, 0));
    ev.chan = dct_pkg::ChanW'($urandom);
    if (armed && $urandom_range(99, 0) < 85) begin
      lo = 64'(cfg_d_lo);
      hi = 64'(cfg_d_hi);
    end else begin
      lo = 64'(cfg_p_lo);
      hi = 64'(cfg_p_hi);
    end
    ev.tot = dct_pkg::EnergyW'(pick_value(lo, hi, EnergyMask));
    ev.e0  = dct_pkg::EnergyW'(pick_value(lo, hi, EnergyMask));
    ev.e1  = dct_pkg::EnergyW'(pick_value(lo, hi, EnergyMask));
    if (armed && $urandom_range(99, 0) < 80)
      ev.t = held_t + dct_pkg::TimeW'(pick_value(64'(cfg_g_lo), 64'(cfg_g_hi), TimeMask));
    else if ($urandom_range(1, 0) == 0)
      ev.t = rand40();
    else
      ev.t = dct_pkg::TimeW'($urandom_range(100000, 0));
    return ev;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_event(input event_t ev, input check_kind_t kind, input tag_t typed);
    tag_t tag;
    bit   has;
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ev;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = predict_tag(ev, tag);
    if (kind == TYPED_TAG) begin
      has = 1'b1;
      tag = typed;
    end else if (kind == TYPED_NONE) begin
      has = 1'b0;
    end
    if (has) pending_tags = {pending_tags, tag};
    events_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // upper pwdata bits above the register width carry junk on purpose
  task automatic reg_write(input dct_pkg::reg_index_t idx, input logic [63:0] val);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    case (idx)
      dct_pkg::REG_CUT_MODE:
        pwdata <= (val & 64'h1) | (junk & ~64'h1);
      dct_pkg::REG_GAP_LOW, dct_pkg::REG_GAP_HIGH:
        pwdata <= (val & TimeMask) | (junk & ~TimeMask);
      default:
        pwdata <= (val & EnergyMask) | (junk & ~EnergyMask);
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      dct_pkg::REG_CUT_MODE:       cfg_broad = val[0];
      dct_pkg::REG_PROMPT_E_LOW:   cfg_p_lo  = val[dct_pkg::EnergyW-1:0];
      dct_pkg::REG_PROMPT_E_HIGH:  cfg_p_hi  = val[dct_pkg::EnergyW-1:0];
      dct_pkg::REG_DELAYED_E_LOW:  cfg_d_lo  = val[dct_pkg::EnergyW-1:0];
      dct_pkg::REG_DELAYED_E_HIGH: cfg_d_hi  = val[dct_pkg::EnergyW-1:0];
      dct_pkg::REG_GAP_LOW:        cfg_g_lo  = val[dct_pkg::TimeW-1:0];
      dct_pkg::REG_GAP_HIGH:       cfg_g_hi  = val[dct_pkg::TimeW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_windows(input logic broad, input logic [63:0] plo, input logic [63:0] phi,
                             input logic [63:0] dlo, input logic [63:0] dhi,
                             input logic [63:0] glo, input logic [63:0] ghi);
    wait_idle();
    reg_write(dct_pkg::REG_CUT_MODE, {63'd0, broad});
    reg_write(dct_pkg::REG_PROMPT_E_LOW, plo);
    reg_write(dct_pkg::REG_PROMPT_E_HIGH, phi);
    reg_write(dct_pkg::REG_DELAYED_E_LOW, dlo);
    reg_write(dct_pkg::REG_DELAYED_E_HIGH, dhi);
    reg_write(dct_pkg::REG_GAP_LOW, glo);
    reg_write(dct_pkg::REG_GAP_HIGH, ghi);
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tag_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_tags.size() == 0) begin
        $error("tag transaction with nothing expected: %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_tags.pop_front();
        check_field("tag_prompt_channel", 64'(want.p_chan), 64'(got.p_chan));
        check_field("tag_delayed_channel", 64'(want.d_chan), 64'(got.d_chan));
        check_field("tag_prompt_energy", 64'(want.p_en), 64'(got.p_en));
        check_field("tag_delayed_energy", 64'(want.d_en), 64'(got.d_en));
        check_field("tag_prompt_time", 64'(want.p_t), 64'(got.p_t));
        check_field("tag_delayed_time", 64'(want.d_t), 64'(got.d_t));
        check_field("energy_sum", 64'(want.sum), 64'(got.sum));
        check_field("time_gap", 64'(want.gap), 64'(got.gap));
      end
      tags_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d tags outstanding", pending_tags.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    tag_t        typed;
    event_t      ev;
    int          phase;
    logic [63:0] lo, glo;

    cfg_broad = 1'b0;
    cfg_p_lo  = dct_pkg::PromptLowReset;
    cfg_p_hi  = dct_pkg::PromptHighReset;
    cfg_d_lo  = dct_pkg::DelayedLowReset;
    cfg_d_hi  = dct_pkg::DelayedHighReset;
    cfg_g_lo  = dct_pkg::GapLowReset;
    cfg_g_hi  = dct_pkg::GapHighReset;
    cur_chain = dct_pkg::ChainReset;
    armed     = 1'b0;
    held_en   = '0;
    held_t    = '0;
    held_chan = '0;

    typed = '0;
    typed.p_chan = 10'd5;
    typed.d_chan = 10'd7;
    typed.p_en   = 20'd102000;
    typed.d_en   = 20'd31000;
    typed.p_t    = 40'd100;
    typed.d_t    = 40'd200;
    typed.sum    = 21'd133000;
    typed.gap    = 40'd100;

    // reset windows, narrow cut
    add_row(mk_event(1, 2, 5, 100, 0, 0, 102000), TYPED_NONE, '0);
    add_row(mk_event(1, 2, 7, 200, 0, 0, 31000), TYPED_TAG, typed);
    add_row(mk_event(1, 2, 8, 300, 0, 31000, 0), BY_PREDICTOR, '0);
    add_row(mk_event(1, 2, 9, 400, 0, 30800, 31900), BY_PREDICTOR, '0);
    add_row(mk_event(1, 2, 10, 100, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 2, 11, 40, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 2, 12, 110, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 2, 13, 111, 0, 0, 31000), BY_PREDICTOR, '0);
    add_row(mk_event(1, 2, 14, 1800100, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 2, 15, 1800099, 0, 0, 31000), BY_PREDICTOR, '0);
    add_row(mk_event(1, 2, 16, 500, 31000, 32000, 30720), TYPED_NONE, '0);
    add_row(mk_event(1, 0, 17, 500, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 255, 18, 500, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 3, 19, 500, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(1, 255, 1023, 40'hFF_FFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
            TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 20, 600, 0, 0, 102000), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 21, 650, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 22, 700, 0, 0, 101568), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 23, 750, 0, 0, 102848), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 24, 800, 0, 101569, 0), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 0, 40'hFF_FFFF_FFFF, 0, 0, 31999), TYPED_NONE, '0);
    add_row(mk_event(32'hFFFF_FFFF, 2, 1023, 1800, 0, 0, 30721), BY_PREDICTOR, '0);
    add_row(mk_event(0, 2, 25, 900, 0, 0, 31000), TYPED_NONE, '0);
    add_row(mk_event(0, 0, 0, 0, 0, 0, 0), TYPED_NONE, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].kind, directed_rows[i].tag);
    wait_idle();

    // output held off while a run of matching delayed events keeps arriving
    hold_req = 300;
    send_event(mk_event(77, 2, 1, 0, 0, 0, 0), BY_PREDICTOR, '0);
    send_event(mk_event(77, 2, 2, 1000, 0, 0, 102000), BY_PREDICTOR, '0);
    for (int i = 0; i < 60; i++) begin
      ev = mk_event(77, 2, dct_pkg::ChanW'($urandom), dct_pkg::TimeW'(1020 + i), 0, 0,
                    dct_pkg::EnergyW'(31000 + i));
      send_event(ev, BY_PREDICTOR, '0);
    end
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_windows(1'b1, 64'(dct_pkg::PromptLowReset), 64'(dct_pkg::PromptHighReset),
                       64'(dct_pkg::DelayedLowReset), 64'(dct_pkg::DelayedHighReset),
                       64'(dct_pkg::GapLowReset), 64'(dct_pkg::GapHighReset));
        1: begin
          lo  = $urandom & EnergyMask;
          glo = 64'($urandom_range(1000, 0));
          set_windows(1'b0, lo, span_above(lo, 4000, EnergyMask), lo ^ 64'h8_0000,
                      span_above(lo ^ 64'h8_0000, 4000, EnergyMask),
                      glo, span_above(glo, 100000, TimeMask));
        end
        2: set_windows(1'b0, 0, EnergyMask, 0, EnergyMask, 0, TimeMask);
        3: begin
          lo  = $urandom & EnergyMask;
          glo = 64'(rand40()) >> 2;
          set_windows(1'b1, lo, span_above(lo, 60000, EnergyMask), lo >> 1,
                      span_above(lo >> 1, 60000, EnergyMask),
                      glo, span_above(glo, 32'h7FFF_FFFF, TimeMask));
        end
        4: begin
          lo  = $urandom & EnergyMask;
          glo = 64'(rand40());
          set_windows(1'b0, lo >> 1, span_above(lo >> 1, 4000, EnergyMask), lo,
                      lo >> $urandom_range(4, 0), glo, glo);
        end
        5: set_windows(1'b1, 0, EnergyMask, 64'(dct_pkg::DelayedLowReset),
                       64'(dct_pkg::DelayedHighReset), 0, 2);
        6: begin
          lo  = $urandom & EnergyMask;
          glo = 64'(rand40());
          set_windows(1'b0, lo, span_above(lo, 20000, EnergyMask), lo,
                      span_above(lo, 20000, EnergyMask), glo,
                      span_above(glo, 32'hFFFF_FFFF, TimeMask));
        end
        default: begin
          // flip the cut while a prompt is likely held; stray address is ignored
          wait_idle();
          reg_write(dct_pkg::REG_CUT_MODE, {63'd0, ~cfg_broad});
          reg_write(dct_pkg::REG_UNUSED, {$urandom, $urandom});
          settings_used++;
        end
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (200) send_event(rand_event(), BY_PREDICTOR, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d events sent, %0d coincidence tags compared", events_sent, tags_checked);
    $display("%0d window settings, narrow and broad cuts, stalls on both sides",
             settings_used);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
